[rtl/col2im_accumulator_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the col2im accumulator core
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef COL2IM_ACCUMULATOR_CORE_MACROS_SVH
`define COL2IM_ACCUMULATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define C2I_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define C2I_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) else $error(msg);
`else
`define C2I_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define C2I_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/c2i_pkg.sv]
// ----------------------------------------------------------------------------
// c2i_pkg
// Types and constants shared by the col2im accumulator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package c2i_pkg;

   localparam int MAX_KERNEL  = 8;
   localparam int MAX_COL_DIM = 64;

   // Index width of an image position after the range check (image size <= 127).
   localparam int POS_W       = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;

   localparam logic [1:0] MODE_FILL = 2'd0;
   localparam logic [1:0] MODE_ACC  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PAD_ROWS      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PAD_COLS      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STRIDE_ROWS   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STRIDE_COLS   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_DILATION_ROWS = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_DILATION_COLS = 3'd7;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_FILL = 2'd1,
      OP_ACC  = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [3:0]         channel;
      logic [2:0]         kernel_row;
      logic [2:0]         kernel_col;
      logic [5:0]         col_row;
      logic [5:0]         col_col;
      logic [5:0]         image_row;
      logic [5:0]         image_col;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pixel_value;
      logic               in_range;
   } rsp_type;

   // One classified command as it waits between front and back.
   typedef struct packed {
      op_type             op;
      logic [3:0]         channel;
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   col;
      logic signed [31:0] value;
   } cmd_type;

   typedef struct packed {
      logic       empty;
      logic       full;
      logic [1:0] count;
   } queue_status_type;

endpackage

`default_nettype wire

[rtl/c2i_front.sv]
// ----------------------------------------------------------------------------
// c2i_front
// Configuration registers, position mapping and request classification.
// ----------------------------------------------------------------------------
`default_nettype none

module c2i_front
   import c2i_pkg::*;
#(
   parameter int MAX_CHANNELS  = 16,
   parameter int MAX_IMAGE_DIM = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_payload,
   input  wire queue_status_type       q_status,
   output logic                        q_push,
   output cmd_type                     q_cmd
);

   logic [6:0] image_height_ff, image_width_ff;
   logic [3:0] pad_rows_ff, pad_cols_ff;
   logic [3:0] stride_rows_ff, stride_cols_ff;
   logic [3:0] dilation_rows_ff, dilation_cols_ff;

   logic [6:0]  height_used, width_used;
   logic [11:0] row_pos, col_pos;
   logic        ch_ok, tap_ok, acc_inside, read_inside;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_height_ff  <= 7'd64;
         image_width_ff   <= 7'd64;
         pad_rows_ff      <= 4'd0;
         pad_cols_ff      <= 4'd0;
         stride_rows_ff   <= 4'd1;
         stride_cols_ff   <= 4'd1;
         dilation_rows_ff <= 4'd1;
         dilation_cols_ff <= 4'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IMAGE_HEIGHT:  image_height_ff  <= csr_wdata;
            REG_IMAGE_WIDTH:   image_width_ff   <= csr_wdata;
            REG_PAD_ROWS:      pad_rows_ff      <= csr_wdata[3:0];
            REG_PAD_COLS:      pad_cols_ff      <= csr_wdata[3:0];
            REG_STRIDE_ROWS:   stride_rows_ff   <= csr_wdata[3:0];
            REG_STRIDE_COLS:   stride_cols_ff   <= csr_wdata[3:0];
            REG_DILATION_ROWS: dilation_rows_ff <= csr_wdata[3:0];
            REG_DILATION_COLS: dilation_cols_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Image size in use, clamped to the store's plane size.
   assign height_used = (int'(image_height_ff) > MAX_IMAGE_DIM) ?
                        7'(MAX_IMAGE_DIM) : image_height_ff;
   assign width_used  = (int'(image_width_ff) > MAX_IMAGE_DIM) ?
                        7'(MAX_IMAGE_DIM) : image_width_ff;

   // Mapped position; bit 11 set means the padding pushed it negative.
   assign row_pos = 12'(req_payload.col_row) * 12'(stride_rows_ff)
                  + 12'(req_payload.kernel_row) * 12'(dilation_rows_ff)
                  - 12'(pad_rows_ff);
   assign col_pos = 12'(req_payload.col_col) * 12'(stride_cols_ff)
                  + 12'(req_payload.kernel_col) * 12'(dilation_cols_ff)
                  - 12'(pad_cols_ff);

   assign ch_ok  = int'(req_payload.channel) < MAX_CHANNELS;
   assign tap_ok = (int'(req_payload.kernel_row) < MAX_KERNEL)
                && (int'(req_payload.kernel_col) < MAX_KERNEL)
                && (int'(req_payload.col_row) < MAX_COL_DIM)
                && (int'(req_payload.col_col) < MAX_COL_DIM);

   assign acc_inside  = tap_ok
                     && !row_pos[11] && (row_pos < 12'(height_used))
                     && !col_pos[11] && (col_pos < 12'(width_used));
   assign read_inside = ({1'b0, req_payload.image_row} < height_used)
                     && ({1'b0, req_payload.image_col} < width_used);

   always_comb begin
      q_cmd         = '0;
      q_cmd.op      = OP_NONE;
      q_cmd.channel = req_payload.channel;
      q_cmd.value   = req_payload.value;
      case (req_payload.mode)
         MODE_FILL: begin
            if (ch_ok) begin
               q_cmd.op = OP_FILL;
            end
         end
         MODE_ACC: begin
            if (ch_ok && acc_inside) begin
               q_cmd.op  = OP_ACC;
               q_cmd.row = row_pos[POS_W-1:0];
               q_cmd.col = col_pos[POS_W-1:0];
            end
         end
         MODE_READ: begin
            if (ch_ok && read_inside) begin
               q_cmd.op  = OP_READ;
               q_cmd.row = POS_W'(req_payload.image_row);
               q_cmd.col = POS_W'(req_payload.image_col);
            end
         end
         default: ;
      endcase
   end

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

endmodule

`default_nettype wire

[rtl/c2i_queue.sv]
// ----------------------------------------------------------------------------
// c2i_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module c2i_queue
   import c2i_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire cmd_type    push_cmd,
   input  wire logic       pop,
   output cmd_type         head,
   output queue_status_type status
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign status.count = count_ff;

endmodule

`default_nettype wire

[rtl/c2i_back.sv]
// ----------------------------------------------------------------------------
// c2i_back
// Image store with the fill, accumulate and read sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module c2i_back
   import c2i_pkg::*;
#(
   parameter int MAX_CHANNELS  = 16,
   parameter int MAX_IMAGE_DIM = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_status,
   input  wire cmd_type          q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_payload
);

   localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int DIM_W   = $clog2(MAX_IMAGE_DIM);
   localparam int PLANE_W = 2 * DIM_W;
   localparam int ADDR_W  = CH_W + PLANE_W;
   localparam int DEPTH   = 2 ** ADDR_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_FILL   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [PLANE_W-1:0]  fill_cnt_ff, fill_cnt_in;
   op_type              cur_op_ff;
   logic [CH_W-1:0]     cur_ch_ff;
   logic [ADDR_W-1:0]   cur_addr_ff;
   logic signed [31:0]  cur_value_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_payload_ff, rsp_payload_in;

   logic signed [31:0]  store [DEPTH];
   logic signed [31:0]  rdata_ff;
   logic [ADDR_W-1:0]   head_addr, waddr;
   logic                we;
   logic signed [31:0]  wdata;
   logic signed [32:0]  sum;
   logic signed [31:0]  sat_sum;
   logic                slot_free;

   assign head_addr = {CH_W'(q_head.channel), DIM_W'(q_head.row), DIM_W'(q_head.col)};
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == ST_IDLE) && !q_status.empty && slot_free;

   assign sum     = {rdata_ff[31], rdata_ff} + {cur_value_ff[31], cur_value_ff};
   assign sat_sum = (sum[32] != sum[31]) ? (sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                         : sum[31:0];

   always_comb begin
      state_in       = state_ff;
      fill_cnt_in    = fill_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      we             = 1'b0;
      waddr          = cur_addr_ff;
      wdata          = sat_sum;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               case (q_head.op)
                  OP_FILL: begin
                     fill_cnt_in = '0;
                     state_in    = ST_FILL;
                  end
                  OP_ACC, OP_READ: begin
                     state_in = ST_LOOKUP;
                  end
                  default: begin
                     rsp_valid_in   = 1'b1;
                     rsp_payload_in = '0;
                  end
               endcase
            end
         end
         ST_FILL: begin
            we          = 1'b1;
            waddr       = {cur_ch_ff, fill_cnt_ff};
            wdata       = cur_value_ff;
            fill_cnt_in = fill_cnt_ff + PLANE_W'(1);
            if (&fill_cnt_ff) begin
               rsp_valid_in               = 1'b1;
               rsp_payload_in.pixel_value = cur_value_ff;
               rsp_payload_in.in_range    = 1'b1;
               state_in                   = ST_IDLE;
            end
         end
         ST_LOOKUP: begin
            rsp_valid_in            = 1'b1;
            rsp_payload_in.in_range = 1'b1;
            if (cur_op_ff == OP_ACC) begin
               we                         = 1'b1;
               rsp_payload_in.pixel_value = sat_sum;
            end else begin
               rsp_payload_in.pixel_value = rdata_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_cnt_ff  <= fill_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (q_pop) begin
         cur_op_ff    <= q_head.op;
         cur_ch_ff    <= CH_W'(q_head.channel);
         cur_addr_ff  <= head_addr;
         cur_value_ff <= q_head.value;
      end
   end

   // One write port and one registered read port, each used once a cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         store[waddr] <= wdata;
      end
      rdata_ff <= store[head_addr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

[rtl/col2im_accumulator_core.sv]
// ----------------------------------------------------------------------------
// col2im_accumulator_core
// Column-to-image scatter-accumulate engine on Q16.16 values.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake             Carries
//   req_      in          req_valid/req_stall   one request (mode, indices, value)
//   rsp_      out         rsp_valid/rsp_stall   pixel_value and in_range
//   csr_      in          csr_valid/csr_ready   register index and write data
//
// A read or accumulate request reads the image store as it leaves the queue,
// and the lookup state then forms the result and, for an accumulate, writes
// the saturated sum back. A bias fill leaves the queue and then writes one
// pixel a cycle over the whole plane. Requests that touch no pixel are
// answered from the idle state with a zero result. Reset is synchronous
// and active high; it clears control state only, the image store is not
// cleared. The front keeps accepting requests until the two-entry queue is
// full, and a stalled result holds the back end without blocking the front.
//
`default_nettype none

module col2im_accumulator_core
   import c2i_pkg::*;
#(
   parameter int MAX_CHANNELS  = 16,
   parameter int MAX_IMAGE_DIM = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_payload,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "col2im_accumulator_core_macros.svh"

   // Front to queue: the classified command and its push strobe.
   logic             q_push;
   cmd_type          q_cmd;
   // Queue to back: the oldest command, its status and the pop strobe.
   cmd_type          q_head;
   queue_status_type q_status;
   logic             q_pop;

   // The front maps each request to a pixel, does every range check and turns
   // the request into one of four commands: fill, accumulate, read or none.
   c2i_front #(
      .MAX_CHANNELS  (MAX_CHANNELS),
      .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_cmd       (q_cmd)
   );

   // The queue decouples the two halves, so a long plane fill does not stop
   // the front from taking the next request.
   c2i_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   // The back owns the image store and the result register. It only pops a
   // command when the result register is free, so a result is never lost.
   c2i_back #(
      .MAX_CHANNELS  (MAX_CHANNELS),
      .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // The back end must never take a command from an empty queue.
   `C2I_ASSERT_IMP(a_pop_not_empty, clock, reset, q_pop, !q_status.empty, "pop from empty queue")

   // The queue fill level tracks pushes and pops exactly.
   `C2I_ASSERT_NEXT(a_count_tracks, clock, reset, 1'b1, (q_status.count == $past(q_status.count) + 2'($past(q_push)) - 2'($past(q_pop))), "queue count drift")

   // A read result is presented after its command has left the queue and passed the lookup state.
   `C2I_ASSERT_NEXT(a_read_latency, clock, reset, (q_pop && (q_head.op == OP_READ)), ##1 rsp_valid, "read result late")

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Testbench for col2im_accumulator_core
// Drives bias fills, column-element accumulates, pixel reads and unused-mode
// requests through the request channel and checks each result field against
// a typed value or a shadow store prediction, over several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
   import c2i_pkg::*;
();

   localparam int CHANNELS        = 16;
   localparam int IMAGE_DIM       = 64;
   localparam int PHASES          = 8;
   localparam int RANDOM_PHASE    = 6;
   localparam int ITEMS_PER_PHASE = 235;
   localparam int DIRECTED_COUNT  = 22;
   localparam int WATCHDOG_CYCLES = 20000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int REPORT_LIMIT    = 10;

   // The fourth mode code is unused by the block and must answer with zeros.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam longint PIXEL_MAX = 64'sd2147483647;
   localparam longint PIXEL_MIN = -64'sd2147483648;

   localparam logic TYPED     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   localparam logic [CSR_INDEX_W-1:0] REGISTER_ORDER [8] = '{
      REG_IMAGE_HEIGHT, REG_IMAGE_WIDTH, REG_PAD_ROWS, REG_PAD_COLS,
      REG_STRIDE_ROWS, REG_STRIDE_COLS, REG_DILATION_ROWS, REG_DILATION_COLS
   };

   // Clock and reset. Reset is held from time zero and released at a falling edge.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Block ports, all driven to known values from time zero.
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   col2im_accumulator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Shadow of the block: the image store, which planes have had a bias fill,
   // and the register file as the block should hold it.
   logic [31:0]   image_model [CHANNELS][IMAGE_DIM][IMAGE_DIM];
   bit [CHANNELS-1:0] plane_filled = '0;
   logic [6:0]    cfg_regs [8] = '{7'd64, 7'd64, 7'd0, 7'd0, 7'd1, 7'd1, 7'd1, 7'd1};

   // Results still owed by the block, oldest first.
   rsp_type pending_pixels [$];

   int  fail_count   = 0;
   int  quiet_cycles = 0;

   // When calm is set neither side idles, so back-to-back traffic is seen.
   bit  calm = 1'b1;

   // The last accumulate that landed inside the image. Later requests reuse it
   // so that the same pixel is hit back to back and read afterwards.
   req_type hot_request;
   int      hot_row;
   int      hot_col;
   bit      hot_valid = 1'b0;

   // Register settings per phase, in register index order. The phase marked as
   // random draws every register afresh, including out-of-range bits.
   logic [6:0] phase_settings [PHASES][8] = '{
      '{7'd64,  7'd64,  7'd0,  7'd0,  7'd1,  7'd1,  7'd1,  7'd1},
      '{7'd127, 7'd127, 7'd15, 7'd15, 7'd15, 7'd15, 7'd15, 7'd15},
      '{7'd1,   7'd1,   7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
      '{7'd0,   7'd0,   7'd3,  7'd5,  7'd2,  7'd3,  7'd1,  7'd2},
      '{7'd32,  7'd48,  7'd2,  7'd1,  7'd2,  7'd3,  7'd1,  7'd2},
      '{7'd64,  7'd17,  7'd15, 7'd0,  7'd1,  7'd8,  7'd8,  7'd1},
      '{7'd0,   7'd0,   7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
      '{7'd100, 7'd65,  7'd7,  7'd7,  7'd4,  7'd4,  7'd2,  7'd2}
   };

   // Directed requests. Rows marked TYPED carry the result that must come
   // back; rows marked PREDICTED are checked against the shadow store.
   typedef struct packed {
      req_type request;
      logic    literal_check;
      rsp_type result;
   } directed_row_type;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      // Bias fills at zero and at both ends of the signed range.
      {MODE_FILL,   4'd0,  3'd0, 3'd0, 6'd0,  6'd0,  6'd0,  6'd0,  32'h0000_0000,
       TYPED, 32'h0000_0000, 1'b1},
      {MODE_FILL,   4'd15, 3'd7, 3'd7, 6'd63, 6'd63, 6'd63, 6'd63, 32'h7FFF_FFFF,
       TYPED, 32'h7FFF_FFFF, 1'b1},
      {MODE_FILL,   4'd5,  3'd0, 3'd0, 6'd0,  6'd0,  6'd0,  6'd0,  32'h8000_0000,
       TYPED, 32'h8000_0000, 1'b1},
      // Reads at the corners of the filled planes.
      {MODE_READ,   4'd0,  3'd0, 3'd0, 6'd0,  6'd0,  6'd0,  6'd0,  32'hFFFF_FFFF,
       TYPED, 32'h0000_0000, 1'b1},
      {MODE_READ,   4'd15, 3'd0, 3'd0, 6'd0,  6'd0,  6'd63, 6'd63, 32'h0000_0000,
       TYPED, 32'h7FFF_FFFF, 1'b1},
      {MODE_READ,   4'd5,  3'd0, 3'd0, 6'd0,  6'd0,  6'd63, 6'd0,  32'h0000_0000,
       TYPED, 32'h8000_0000, 1'b1},
      // Accumulates that saturate high and low.
      {MODE_ACC,    4'd15, 3'd0, 3'd0, 6'd0,  6'd0,  6'd0,  6'd0,  32'h0000_0001,
       TYPED, 32'h7FFF_FFFF, 1'b1},
      {MODE_ACC,    4'd5,  3'd0, 3'd0, 6'd0,  6'd0,  6'd0,  6'd0,  32'hFFFF_FFFF,
       TYPED, 32'h8000_0000, 1'b1},
      // Largest column indices: the far corner is inside, a kernel tap beyond it is not.
      {MODE_ACC,    4'd0,  3'd0, 3'd0, 6'd63, 6'd63, 6'd0,  6'd0,  32'h0001_0000,
       TYPED, 32'h0001_0000, 1'b1},
      {MODE_ACC,    4'd0,  3'd7, 3'd0, 6'd63, 6'd0,  6'd0,  6'd0,  32'h0001_0000,
       TYPED, 32'h0000_0000, 1'b0},
      {MODE_ACC,    4'd0,  3'd0, 3'd7, 6'd0,  6'd63, 6'd0,  6'd0,  32'h0001_0000,
       TYPED, 32'h0000_0000, 1'b0},
      // Three hits on one pixel in a row: the sum must be forwarded each time.
      {MODE_ACC,    4'd0,  3'd7, 3'd7, 6'd0,  6'd0,  6'd0,  6'd0,  32'h7FFF_FFFF,
       TYPED, 32'h7FFF_FFFF, 1'b1},
      {MODE_ACC,    4'd0,  3'd7, 3'd7, 6'd0,  6'd0,  6'd0,  6'd0,  32'h7FFF_FFFF,
       TYPED, 32'h7FFF_FFFF, 1'b1},
      {MODE_ACC,    4'd0,  3'd7, 3'd7, 6'd0,  6'd0,  6'd0,  6'd0,  32'h8000_0000,
       TYPED, 32'hFFFF_FFFF, 1'b1},
      {MODE_READ,   4'd0,  3'd0, 3'd0, 6'd0,  6'd0,  6'd7,  6'd7,  32'h0000_0000,
       TYPED, 32'hFFFF_FFFF, 1'b1},
      // The unused mode code with every other field at its top.
      {MODE_UNUSED, 4'd15, 3'd7, 3'd7, 6'd63, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF,
       TYPED, 32'h0000_0000, 1'b0},
      {MODE_READ,   4'd0,  3'd0, 3'd0, 6'd0,  6'd0,  6'd63, 6'd63, 32'h0000_0000,
       TYPED, 32'h0001_0000, 1'b1},
      // An ordinary fill, accumulate and read-back on a fresh plane.
      {MODE_FILL,   4'd10, 3'd0, 3'd0, 6'd0,  6'd0,  6'd0,  6'd0,  32'h0001_8000,
       TYPED, 32'h0001_8000, 1'b1},
      {MODE_READ,   4'd10, 3'd0, 3'd0, 6'd0,  6'd0,  6'd32, 6'd17, 32'h0000_0000,
       TYPED, 32'h0001_8000, 1'b1},
      {MODE_ACC,    4'd10, 3'd3, 3'd5, 6'd31, 6'd42, 6'd0,  6'd0,  32'hFFFF_0000,
       PREDICTED, 32'h0000_0000, 1'b0},
      {MODE_READ,   4'd10, 3'd0, 3'd0, 6'd0,  6'd0,  6'd34, 6'd47, 32'h0000_0000,
       PREDICTED, 32'h0000_0000, 1'b0},
      {MODE_UNUSED, 4'd0,  3'd0, 3'd0, 6'd0,  6'd0,  6'd0,  6'd0,  32'h0000_0000,
       TYPED, 32'h0000_0000, 1'b0}
   };

   // Image size registers above the store size are clamped to it.
   function automatic int used_dim(input logic [6:0] size);
      return (size > IMAGE_DIM) ? IMAGE_DIM : int'(size);
   endfunction

   // Maps a column element to its image pixel and says whether the pixel lies
   // inside the image in use. Zero strides and dilations are taken as they are.
   function automatic bit locate_pixel(input req_type r, output int row, output int col);
      row = int'(r.col_row) * int'(cfg_regs[REG_STRIDE_ROWS]) - int'(cfg_regs[REG_PAD_ROWS])
            + int'(r.kernel_row) * int'(cfg_regs[REG_DILATION_ROWS]);
      col = int'(r.col_col) * int'(cfg_regs[REG_STRIDE_COLS]) - int'(cfg_regs[REG_PAD_COLS])
            + int'(r.kernel_col) * int'(cfg_regs[REG_DILATION_COLS]);
      return row >= 0 && row < used_dim(cfg_regs[REG_IMAGE_HEIGHT]) &&
             col >= 0 && col < used_dim(cfg_regs[REG_IMAGE_WIDTH]);
   endfunction

   // Applies one request to the shadow store and returns the result the block
   // owes for it.
   function automatic rsp_type update_image(input req_type r);
      rsp_type res;
      int      row;
      int      col;
      int      i;
      int      j;
      longint  sum;
      res = '0;
      case (r.mode)
         MODE_FILL: begin
            for (i = 0; i < IMAGE_DIM; i++) begin
               for (j = 0; j < IMAGE_DIM; j++) begin
                  image_model[r.channel][i][j] = r.value;
               end
            end
            plane_filled[r.channel] = 1'b1;
            res.pixel_value = r.value;
            res.in_range    = 1'b1;
         end
         MODE_ACC: begin
            if (locate_pixel(r, row, col)) begin
               sum = longint'($signed(image_model[r.channel][row][col]))
                     + longint'($signed(r.value));
               if (sum > PIXEL_MAX) begin
                  sum = PIXEL_MAX;
               end else if (sum < PIXEL_MIN) begin
                  sum = PIXEL_MIN;
               end
               image_model[r.channel][row][col] = sum[31:0];
               res.pixel_value = sum[31:0];
               res.in_range    = 1'b1;
            end
         end
         MODE_READ: begin
            if (int'(r.image_row) < used_dim(cfg_regs[REG_IMAGE_HEIGHT]) &&
                int'(r.image_col) < used_dim(cfg_regs[REG_IMAGE_WIDTH])) begin
               res.pixel_value = image_model[r.channel][r.image_row][r.image_col];
               res.in_range    = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Idle stretches: mostly none or short, now and then long.
   function automatic int unsigned idle_length();
      int unsigned pick;
      if (calm) begin
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 0;
      end else if (pick < 85) begin
         return $urandom_range(1, 3);
      end else if (pick < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Q16.16 values: mostly small, some anywhere, some near the saturation limits.
   function automatic logic signed [31:0] random_value();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
         return int'($urandom_range(0, 2097152)) - 1048576;
      end else if (pick < 14) begin
         return 32'h7FFF_FF00 | $urandom_range(0, 255);
      end else if (pick < 17) begin
         return 32'h8000_0000 | $urandom_range(0, 255);
      end
      return $urandom;
   endfunction

   // Builds one random request. Most are accumulates aimed inside the image
   // and reads of pixels that were just updated; fields a mode ignores carry
   // random noise. Accumulates and reads only name planes that have been
   // filled, since the store holds nothing defined before a bias fill.
   function automatic req_type random_request();
      req_type         r;
      logic [95:0]     noise;
      int unsigned     pick;
      int unsigned     tries;
      int              bound_r;
      int              bound_c;
      int              row;
      int              col;
      noise = {$urandom, $urandom, $urandom};
      r = noise[$bits(req_type)-1:0];
      r.value = random_value();
      pick = $urandom_range(0, 999);
      if (pick < 12) begin
         r.mode = MODE_FILL;
         return r;
      end
      if (pick < 52) begin
         r.mode = MODE_UNUSED;
         return r;
      end
      do begin
         r.channel = 4'($urandom_range(0, CHANNELS - 1));
      end while (!plane_filled[r.channel]);
      if (pick < 300) begin
         r.mode = MODE_READ;
         if (hot_valid && $urandom_range(0, 1) == 1) begin
            r.channel   = hot_request.channel;
            r.image_row = 6'(hot_row);
            r.image_col = 6'(hot_col);
         end
         return r;
      end
      r.mode = MODE_ACC;
      if (hot_valid && $urandom_range(0, 3) == 0) begin
         r.channel    = hot_request.channel;
         r.kernel_row = hot_request.kernel_row;
         r.kernel_col = hot_request.kernel_col;
         r.col_row    = hot_request.col_row;
         r.col_col    = hot_request.col_col;
         return r;
      end
      if ($urandom_range(0, 4) != 0) begin
         // Keep column indices within the span that can still land in the image.
         bound_r = (cfg_regs[REG_STRIDE_ROWS] == 0) ? 63 :
                   (used_dim(cfg_regs[REG_IMAGE_HEIGHT]) + int'(cfg_regs[REG_PAD_ROWS]))
                   / int'(cfg_regs[REG_STRIDE_ROWS]);
         bound_c = (cfg_regs[REG_STRIDE_COLS] == 0) ? 63 :
                   (used_dim(cfg_regs[REG_IMAGE_WIDTH]) + int'(cfg_regs[REG_PAD_COLS]))
                   / int'(cfg_regs[REG_STRIDE_COLS]);
         if (bound_r > 63) begin
            bound_r = 63;
         end
         if (bound_c > 63) begin
            bound_c = 63;
         end
         for (tries = 0; tries < 24; tries++) begin
            r.kernel_row = 3'($urandom_range(0, 7));
            r.kernel_col = 3'($urandom_range(0, 7));
            r.col_row    = 6'($urandom_range(0, bound_r));
            r.col_col    = 6'($urandom_range(0, bound_c));
            if (locate_pixel(r, row, col)) begin
               break;
            end
         end
      end
      if (locate_pixel(r, row, col)) begin
         hot_request = r;
         hot_row     = row;
         hot_col     = col;
         hot_valid   = 1'b1;
      end
      return r;
   endfunction

   function automatic void note_mismatch(input string what, input rsp_type want,
                                         input rsp_type got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("mismatch on %s: expected pixel %h in_range %b, got pixel %h in_range %b",
                  what, want.pixel_value, want.in_range, got.pixel_value, got.in_range);
      end
   endfunction

   // Presents one request after a random gap and holds it until the block
   // takes it. The expected result is queued at the edge of acceptance, so the
   // shadow store sees requests in the block's own order.
   task automatic send_request(input req_type r, input logic literal_check,
                               input rsp_type literal_result);
      rsp_type     predicted;
      int unsigned gap;
      gap = idle_length();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      predicted = update_image(r);
      pending_pixels.push_back(literal_check ? literal_result : predicted);
   endtask

   // Writes one register; the shadow copy keeps only the bits the block holds.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      cfg_regs[index] = (index == REG_IMAGE_HEIGHT || index == REG_IMAGE_WIDTH) ?
                        data : (data & 7'h0F);
   endtask

   // Stops sending and waits until every owed result has arrived, then lets
   // the back end settle before anything else happens.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side back-pressure, changed only at falling edges.
   always begin : result_back_pressure
      int unsigned hold;
      @(negedge clock);
      hold = idle_length();
      if (hold != 0) begin
         rsp_stall <= 1'b1;
         repeat (hold) @(negedge clock);
      end
      rsp_stall <= 1'b0;
   end

   // Every accepted result is matched against the oldest expectation.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            note_mismatch("unexpected result", '0, rsp_payload);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_payload.pixel_value !== want.pixel_value) begin
               note_mismatch("pixel_value", want, rsp_payload);
            end
            if (rsp_payload.in_range !== want.in_range) begin
               note_mismatch("in_range", want, rsp_payload);
            end
         end
      end
   end

   // The run is abandoned if no channel moves anything for far longer than
   // the slowest bias fill could take.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_CYCLES) begin
            $display("col2im_accumulator_core test failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned n;
      int unsigned p;
      int unsigned k;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed requests run on the reset register values without idling,
      // so the repeated hits on one pixel arrive back to back.
      for (n = 0; n < DIRECTED_COUNT; n++) begin
         send_request(directed_rows[n].request, directed_rows[n].literal_check,
                      directed_rows[n].result);
      end

      // Each phase waits for the block to drain, rewrites every register and
      // then streams random requests with idling switched on and off.
      for (p = 0; p < PHASES; p++) begin
         wait_for_results();
         for (k = 0; k < 8; k++) begin
            write_register(REGISTER_ORDER[k], (p == RANDOM_PHASE) ?
                           7'($urandom_range(0, 127)) : phase_settings[p][k]);
         end
         @(negedge clock);
         csr_valid <= 1'b0;
         hot_valid = 1'b0;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 64 == 0) begin
               calm = ($urandom_range(0, 3) == 0);
            end
            send_request(random_request(), PREDICTED, '0);
         end
      end

      wait_for_results();
      if (fail_count == 0) begin
         $display("col2im_accumulator_core test passed");
      end else begin
         $display("col2im_accumulator_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
